// ===== rtl/dcenu_pkg.sv =====
`timescale 1ns / 1ps
package dcenu_pkg;

  // Fixed-point scaling
  localparam int COEF_FRAC_BITS = 14;
  localparam int DATA_FRAC_BITS = 15;

  // Field widths
  localparam int CW = 16;        // coefficient register width
  localparam int DW = 17;        // point / result width
  localparam int NW = DW + 1;    // n after adding one

  // Register file
  localparam int NUM_REGS = 6;
  localparam int IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_SIN_HA  = 3'd0,
    REG_COS_HA  = 3'd1,
    REG_SIN_DEC = 3'd2,
    REG_COS_DEC = 3'd3,
    REG_SIN_LAT = 3'd4,
    REG_COS_LAT = 3'd5
  } reg_idx_t;

  localparam logic signed [CW-1:0] COEF_ONE = CW'(1 << COEF_FRAC_BITS);

  // Arithmetic widths
  localparam int PW    = 2 * CW;                       // coefficient product
  localparam int ENT_A = CW + 2;
  localparam int ENT_B = 2 * CW + 4 - COEF_FRAC_BITS;
  localparam int ENT_W = (ENT_A > ENT_B) ? ENT_A : ENT_B; // matrix entry
  localparam int SW    = ENT_W + CW + 2;               // second-level sum

  // Cycles from a register change to a settled matrix
  localparam int MAT_LAT = 4;
  localparam int BUSY_W  = $clog2(MAT_LAT + 1);

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [DW-1:0] l;
    logic signed [DW-1:0] m;
    logic signed [NW-1:0] n;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] e0;
    logic signed [ENT_W-1:0] e1;
    logic signed [ENT_W-1:0] e2;
    logic signed [ENT_W-1:0] n0;
    logic signed [ENT_W-1:0] n1;
    logic signed [ENT_W-1:0] n2;
    logic signed [ENT_W-1:0] u0;
    logic signed [ENT_W-1:0] u1;
    logic signed [ENT_W-1:0] u2;
  } mat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Round half up, then drop the coefficient fraction
  function automatic logic signed [ENT_W-1:0] rnd_p(input logic signed [PW:0] v);
    logic signed [PW:0] w;
    w = v + ((PW + 1)'(1) <<< (COEF_FRAC_BITS - 1));
    return ENT_W'(w >>> COEF_FRAC_BITS);
  endfunction

  function automatic logic signed [ENT_W-1:0] rnd_s(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] w;
    w = v + (SW'(1) <<< (COEF_FRAC_BITS - 1));
    return ENT_W'(w >>> COEF_FRAC_BITS);
  endfunction

endpackage

// ===== rtl/direction_cosine_to_enu_rotation_top.sv =====
`timescale 1ns / 1ps
// Relative direction cosines to east/north/up, one word per cycle sustained when
// the matrix is settled and the receiver is ready. Each word passes the queue,
// the product stage and the sum/round/saturate stage; the output register
// decouples stalls. A 4-stage coefficient pipeline rebuilds the matrix; after
// reset and after each register write the input is held off until it settles.
// Synchronous active-low reset restores the identity-angle register values.
module direction_cosine_to_enu_rotation_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dcenu_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dcenu_pkg::CW-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [dcenu_pkg::DW-1:0] in_cos_l,
  input  logic signed [dcenu_pkg::DW-1:0] in_cos_m,
  input  logic signed [dcenu_pkg::DW-1:0] in_cos_n_rel,
  input  logic                            in_last_point,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [dcenu_pkg::DW-1:0] out_east,
  output logic signed [dcenu_pkg::DW-1:0] out_north,
  output logic signed [dcenu_pkg::DW-1:0] out_up,
  output logic                            out_last_out
);

  dcenu_pkg::mat_t       mat;
  logic                  coef_busy;
  dcenu_pkg::fifo_stat_t fifo_stat;
  logic                  push, pop;
  dcenu_pkg::item_t      push_item, pop_item;

  dcenu_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat),
    .busy      (coef_busy)
  );

  dcenu_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cos_l      (in_cos_l),
    .in_cos_m      (in_cos_m),
    .in_cos_n_rel  (in_cos_n_rel),
    .in_last_point (in_last_point),
    .coef_busy     (coef_busy),
    .fifo_stat     (fifo_stat),
    .push          (push),
    .push_item     (push_item)
  );

  dcenu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (fifo_stat)
  );

  dcenu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .mat          (mat),
    .fifo_stat    (fifo_stat),
    .pop_item     (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_east     (out_east),
    .out_north    (out_north),
    .out_up       (out_up),
    .out_last_out (out_last_out)
  );

  a_cfg_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken before the matrix settled");

endmodule

// ===== rtl/dcenu_coef.sv =====
`timescale 1ns / 1ps
module dcenu_coef (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dcenu_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dcenu_pkg::CW-1:0]      cfg_data,
  output dcenu_pkg::mat_t               mat,
  output logic                          busy
);

  localparam int CW = dcenu_pkg::CW;
  localparam int PW = dcenu_pkg::PW;
  localparam int SW = dcenu_pkg::SW;
  localparam int EW = dcenu_pkg::ENT_W;

  logic signed [CW-1:0] sh_r, ch_r, sd_r, cd_r, sl_r, cl_r;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r <= '0;
      ch_r <= dcenu_pkg::COEF_ONE;
      sd_r <= '0;
      cd_r <= dcenu_pkg::COEF_ONE;
      sl_r <= '0;
      cl_r <= dcenu_pkg::COEF_ONE;
    end else if (cfg_we) begin
      unique case (dcenu_pkg::reg_idx_t'(cfg_index))
        dcenu_pkg::REG_SIN_HA:  sh_r <= cfg_data;
        dcenu_pkg::REG_COS_HA:  ch_r <= cfg_data;
        dcenu_pkg::REG_SIN_DEC: sd_r <= cfg_data;
        dcenu_pkg::REG_COS_DEC: cd_r <= cfg_data;
        dcenu_pkg::REG_SIN_LAT: sl_r <= cfg_data;
        dcenu_pkg::REG_COS_LAT: cl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Settling counter: matrix is stale until it runs out
  logic [dcenu_pkg::BUSY_W-1:0] busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      busy_r <= dcenu_pkg::BUSY_W'(dcenu_pkg::MAT_LAT);
    end else if (busy_r != '0) begin
      busy_r <= busy_r - 1'b1;
    end
  end

  assign busy = (busy_r != '0);

  // Stage 1: first-level products
  logic signed [PW-1:0] p_slch_r, p_clch_r, p_shsd_r, p_shcd_r, p_slsh_r;
  logic signed [PW-1:0] p_clsh_r, p_clcd_r, p_clsd_r, p_slcd_r, p_slsd_r;

  always_ff @(posedge clk) begin
    p_slch_r <= PW'(sl_r) * PW'(ch_r);
    p_clch_r <= PW'(cl_r) * PW'(ch_r);
    p_shsd_r <= PW'(sh_r) * PW'(sd_r);
    p_shcd_r <= PW'(sh_r) * PW'(cd_r);
    p_slsh_r <= PW'(sl_r) * PW'(sh_r);
    p_clsh_r <= PW'(cl_r) * PW'(sh_r);
    p_clcd_r <= PW'(cl_r) * PW'(cd_r);
    p_clsd_r <= PW'(cl_r) * PW'(sd_r);
    p_slcd_r <= PW'(sl_r) * PW'(cd_r);
    p_slsd_r <= PW'(sl_r) * PW'(sd_r);
  end

  // Stage 2: round the simple entries and the shared terms
  logic signed [EW-1:0] t1_r, t2_r, e1_r, e2_r, n0_r, u0_r;
  logic signed [PW-1:0] p_clcd2_r, p_clsd2_r, p_slcd2_r, p_slsd2_r;

  always_ff @(posedge clk) begin
    t1_r      <= dcenu_pkg::rnd_p((PW + 1)'(p_slch_r));
    t2_r      <= dcenu_pkg::rnd_p((PW + 1)'(p_clch_r));
    e1_r      <= dcenu_pkg::rnd_p((PW + 1)'(p_shsd_r));
    e2_r      <= dcenu_pkg::rnd_p(-((PW + 1)'(p_shcd_r)));
    n0_r      <= dcenu_pkg::rnd_p(-((PW + 1)'(p_slsh_r)));
    u0_r      <= dcenu_pkg::rnd_p((PW + 1)'(p_clsh_r));
    p_clcd2_r <= p_clcd_r;
    p_clsd2_r <= p_clsd_r;
    p_slcd2_r <= p_slcd_r;
    p_slsd2_r <= p_slsd_r;
  end

  // Stage 3: second-level products against declination terms
  logic signed [SW-1:0] q_n1_r, q_n2_r, q_u1_r, q_u2_r;

  always_ff @(posedge clk) begin
    q_n1_r <= SW'(p_clcd2_r) + SW'(t1_r) * SW'(sd_r);
    q_n2_r <= SW'(p_clsd2_r) - SW'(t1_r) * SW'(cd_r);
    q_u1_r <= SW'(p_slcd2_r) - SW'(t2_r) * SW'(sd_r);
    q_u2_r <= SW'(p_slsd2_r) + SW'(t2_r) * SW'(cd_r);
  end

  // Stage 4: settled matrix
  dcenu_pkg::mat_t mat_r;

  always_ff @(posedge clk) begin
    mat_r.e0 <= EW'(ch_r);
    mat_r.e1 <= e1_r;
    mat_r.e2 <= e2_r;
    mat_r.n0 <= n0_r;
    mat_r.n1 <= dcenu_pkg::rnd_s(q_n1_r);
    mat_r.n2 <= dcenu_pkg::rnd_s(q_n2_r);
    mat_r.u0 <= u0_r;
    mat_r.u1 <= dcenu_pkg::rnd_s(q_u1_r);
    mat_r.u2 <= dcenu_pkg::rnd_s(q_u2_r);
  end

  assign mat = mat_r;

endmodule

// ===== rtl/dcenu_front.sv =====
`timescale 1ns / 1ps
module dcenu_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [dcenu_pkg::DW-1:0] in_cos_l,
  input  logic signed [dcenu_pkg::DW-1:0] in_cos_m,
  input  logic signed [dcenu_pkg::DW-1:0] in_cos_n_rel,
  input  logic                          in_last_point,
  input  logic                          coef_busy,
  input  dcenu_pkg::fifo_stat_t         fifo_stat,
  output logic                          push,
  output dcenu_pkg::item_t              push_item
);

  localparam int NW = dcenu_pkg::NW;

  // Hold off while the matrix settles or the queue is full
  assign in_ready = !coef_busy && !fifo_stat.full;
  assign push     = in_valid && in_ready;

  // Undo the relative convention on n: add one in data scale
  always_comb begin
    push_item.l    = in_cos_l;
    push_item.m    = in_cos_m;
    push_item.n    = NW'(in_cos_n_rel) + NW'(1 << dcenu_pkg::DATA_FRAC_BITS);
    push_item.last = in_last_point;
  end

endmodule

// ===== rtl/dcenu_fifo.sv =====
`timescale 1ns / 1ps
module dcenu_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  dcenu_pkg::item_t       push_item,
  input  logic                   pop,
  output dcenu_pkg::item_t       pop_item,
  output dcenu_pkg::fifo_stat_t  stat
);

  localparam int DEPTH = dcenu_pkg::FIFO_DEPTH;
  localparam int PTR_W = dcenu_pkg::PTR_W;
  localparam int CNT_W = dcenu_pkg::CNT_W;

  dcenu_pkg::item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/dcenu_back.sv =====
`timescale 1ns / 1ps
module dcenu_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dcenu_pkg::mat_t                 mat,
  input  dcenu_pkg::fifo_stat_t           fifo_stat,
  input  dcenu_pkg::item_t                pop_item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [dcenu_pkg::DW-1:0] out_east,
  output logic signed [dcenu_pkg::DW-1:0] out_north,
  output logic signed [dcenu_pkg::DW-1:0] out_up,
  output logic                            out_last_out
);

  localparam int DW   = dcenu_pkg::DW;
  localparam int MW   = dcenu_pkg::ENT_W + dcenu_pkg::NW;
  localparam int SUMW = MW + 2;
  localparam logic signed [SUMW-1:0] HALF   = SUMW'(1) <<< (dcenu_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [SUMW-1:0] SAT_HI = (SUMW'(1) <<< (DW - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] SAT_LO = -(SUMW'(1) <<< (DW - 1));

  function automatic logic signed [DW-1:0] row_out(input logic signed [MW-1:0] a,
                                                   input logic signed [MW-1:0] b,
                                                   input logic signed [MW-1:0] c);
    logic signed [SUMW-1:0] s;
    logic signed [SUMW-1:0] r;
    s = SUMW'(a) + SUMW'(b) + SUMW'(c) + HALF;
    r = s >>> dcenu_pkg::COEF_FRAC_BITS;
    if (r > SAT_HI)      return DW'(SAT_HI);
    else if (r < SAT_LO) return DW'(SAT_LO);
    else                 return DW'(r);
  endfunction

  logic v1_r, v2_r;
  logic adv1, adv2;

  assign adv2 = !v2_r || out_ready;
  assign adv1 = !v1_r || adv2;
  assign pop  = !fifo_stat.empty && adv1;

  // Valid bits of the two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= pop;
      if (adv2) v2_r <= v1_r;
    end
  end

  // Stage 1: nine products
  logic signed [MW-1:0] pe0_r, pe1_r, pe2_r, pn0_r, pn1_r, pn2_r, pu0_r, pu1_r, pu2_r;
  logic                 last1_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      pe0_r   <= MW'(mat.e0) * MW'(pop_item.l);
      pe1_r   <= MW'(mat.e1) * MW'(pop_item.m);
      pe2_r   <= MW'(mat.e2) * MW'(pop_item.n);
      pn0_r   <= MW'(mat.n0) * MW'(pop_item.l);
      pn1_r   <= MW'(mat.n1) * MW'(pop_item.m);
      pn2_r   <= MW'(mat.n2) * MW'(pop_item.n);
      pu0_r   <= MW'(mat.u0) * MW'(pop_item.l);
      pu1_r   <= MW'(mat.u1) * MW'(pop_item.m);
      pu2_r   <= MW'(mat.u2) * MW'(pop_item.n);
      last1_r <= pop_item.last;
    end
  end

  // Stage 2: row sums, rounding, saturation into the output register
  logic signed [DW-1:0] east_r, north_r, up_r;
  logic                 last2_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      east_r  <= row_out(pe0_r, pe1_r, pe2_r);
      north_r <= row_out(pn0_r, pn1_r, pn2_r);
      up_r    <= row_out(pu0_r, pu1_r, pu2_r);
      last2_r <= last1_r;
    end
  end

  assign out_valid    = v2_r;
  assign out_east     = east_r;
  assign out_north    = north_r;
  assign out_up       = up_r;
  assign out_last_out = last2_r;

  a_stage1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv1) |=> v1_r)
    else $error("stalled word dropped from product stage");

endmodule

// ===== tb/sv/direction_cosine_to_enu_rotation_top_tb.sv =====
`timescale 1ns / 1ps
module direction_cosine_to_enu_rotation_top_tb;

  localparam int IDX_W          = dcenu_pkg::IDX_W;
  localparam int NUM_REGS       = dcenu_pkg::NUM_REGS;
  localparam int DW             = dcenu_pkg::DW;
  localparam int CW             = dcenu_pkg::CW;
  localparam int COEF_FRAC_BITS = dcenu_pkg::COEF_FRAC_BITS;
  localparam int DATA_FRAC_BITS = dcenu_pkg::DATA_FRAC_BITS;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = IDX_W'(NUM_REGS);
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = '1;
  localparam real PI = 3.14159265358979;

  typedef struct packed {
    logic signed [DW-1:0] east;
    logic signed [DW-1:0] north;
    logic signed [DW-1:0] up;
    logic                 last;
  } enu_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_RARE_STALL, SINK_PERIODIC} sink_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] in_cos_l = '0;
  logic signed [DW-1:0] in_cos_m = '0;
  logic signed [DW-1:0] in_cos_n_rel = '0;
  logic                 in_last_point = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_east;
  logic signed [DW-1:0] out_north;
  logic signed [DW-1:0] out_up;
  logic                 out_last_out;

  // Local copy of the angle registers and the words still owed by the block
  logic signed [CW-1:0] angle_reg [NUM_REGS];
  enu_t                 enu_expected [$];
  int                   err_count = 0;
  int unsigned          cycle_count = 0;
  int                   burst_left = 0;
  int                   gap_percent = 50;

  direction_cosine_to_enu_rotation_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cos_l     (in_cos_l),
    .in_cos_m     (in_cos_m),
    .in_cos_n_rel (in_cos_n_rel),
    .in_last_point(in_last_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_east     (out_east),
    .out_north    (out_north),
    .out_up       (out_up),
    .out_last_out (out_last_out)
  );

  always #1 clk = ~clk;

  // Round half up at coefficient scale (arithmetic shift floors)
  function automatic longint round_coef(input longint v);
    return (v + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  endfunction

  function automatic logic signed [DW-1:0] clamp_data(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -(longint'(1) <<< (DW - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return DW'(v);
  endfunction

  // Rotate one relative point into east/north/up with the current angles
  function automatic enu_t rotate_point(input logic signed [DW-1:0] l_in,
                                        input logic signed [DW-1:0] m_in,
                                        input logic signed [DW-1:0] nrel_in,
                                        input logic last_in);
    longint sh, ch, sd, cd, sl, cl, l, m, n, t1, t2;
    longint e0, e1, e2, n0, n1, n2, u0, u1, u2;
    enu_t r;
    sh = angle_reg[dcenu_pkg::REG_SIN_HA];
    ch = angle_reg[dcenu_pkg::REG_COS_HA];
    sd = angle_reg[dcenu_pkg::REG_SIN_DEC];
    cd = angle_reg[dcenu_pkg::REG_COS_DEC];
    sl = angle_reg[dcenu_pkg::REG_SIN_LAT];
    cl = angle_reg[dcenu_pkg::REG_COS_LAT];
    l = l_in;
    m = m_in;
    n = longint'(nrel_in) + (longint'(1) <<< DATA_FRAC_BITS);
    t1 = round_coef(sl * ch);
    t2 = round_coef(cl * ch);
    e0 = ch;
    e1 = round_coef(sh * sd);
    e2 = round_coef(-(sh * cd));
    n0 = round_coef(-(sl * sh));
    n1 = round_coef(cl * cd + t1 * sd);
    n2 = round_coef(cl * sd - t1 * cd);
    u0 = round_coef(cl * sh);
    u1 = round_coef(sl * cd - t2 * sd);
    u2 = round_coef(sl * sd + t2 * cd);
    r.east  = clamp_data(round_coef(e0 * l + e1 * m + e2 * n));
    r.north = clamp_data(round_coef(n0 * l + n1 * m + n2 * n));
    r.up    = clamp_data(round_coef(u0 * l + u1 * m + u2 * n));
    r.last  = last_in;
    return r;
  endfunction

  // One point word, preceded by a random gap at the end of each burst
  task automatic send_point(input logic signed [DW-1:0] l, input logic signed [DW-1:0] m,
                            input logic signed [DW-1:0] nrel, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 99) < gap_percent) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_cos_l      <= l;
    in_cos_m      <= m;
    in_cos_n_rel  <= nrel;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    enu_expected.push_back(rotate_point(l, m, nrel, last));
  endtask

  // Stop sending and wait for every owed word, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (enu_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_angle(input logic [IDX_W-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx < NUM_REGS) angle_reg[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_angles(input logic [CW-1:0] sh, input logic [CW-1:0] ch,
                            input logic [CW-1:0] sd, input logic [CW-1:0] cd,
                            input logic [CW-1:0] sl, input logic [CW-1:0] cl);
    drain();
    write_angle(dcenu_pkg::REG_SIN_HA, sh);
    write_angle(dcenu_pkg::REG_COS_HA, ch);
    write_angle(dcenu_pkg::REG_SIN_DEC, sd);
    write_angle(dcenu_pkg::REG_COS_DEC, cd);
    write_angle(dcenu_pkg::REG_SIN_LAT, sl);
    write_angle(dcenu_pkg::REG_COS_LAT, cl);
  endtask

  // Sine/cosine pair: mostly a true angle, sometimes loose or raw patterns
  function automatic void angle_coefs(output logic [CW-1:0] s, output logic [CW-1:0] c);
    real a;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      a = $urandom_range(0, 3599) * PI / 1800.0;
      s = CW'($rtoi($floor($sin(a) * 16384.0 + 0.5)));
      c = CW'($rtoi($floor($cos(a) * 16384.0 + 0.5)));
    end else if (pick < 17) begin
      s = CW'(int'($urandom_range(0, 32768)) - 16384);
      c = CW'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      s = CW'($urandom);
      c = CW'($urandom);
    end
  endfunction

  task automatic random_angles();
    logic [CW-1:0] sh, ch, sd, cd, sl, cl;
    angle_coefs(sh, ch);
    angle_coefs(sd, cd);
    angle_coefs(sl, cl);
    set_angles(sh, ch, sd, cd, sl, cl);
  endtask

  // Mostly points within unit range on each axis, the rest anywhere in 17 bits
  task automatic send_random_point();
    logic signed [DW-1:0] l, m, nr;
    if ($urandom_range(0, 4) == 0) begin
      l  = DW'($urandom);
      m  = DW'($urandom);
      nr = DW'($urandom);
    end else begin
      l  = DW'(int'($urandom_range(0, 65536)) - 32768);
      m  = DW'(int'($urandom_range(0, 65536)) - 32768);
      nr = DW'(-int'($urandom_range(0, 32768)));
    end
    send_point(l, m, nr, $urandom_range(0, 31) == 0);
  endtask

  // Reset angles give east = l, north = m, up = n (saturated)
  task automatic test_reset_matrix();
    send_point('0, '0, '0, 1'b0);
    send_point(17'sd65535, 17'sd65535, 17'sd65535, 1'b1);
    send_point(-17'sd65536, -17'sd65536, -17'sd65536, 1'b0);
    send_point(17'sd32768, -17'sd32768, -17'sd32768, 1'b1);
    send_point(-17'sd1, 17'sd1, -17'sd32769, 1'b0);
    send_point(17'sd12345, -17'sd23456, -17'sd4000, 1'b0);
    send_point(17'sd65535, -17'sd65536, 17'sd32767, 1'b1);
  endtask

  // Full-scale, inverted and out-of-range coefficients with extreme points
  task automatic test_extreme_angles();
    logic [CW-1:0] vals [4];
    vals = '{16'h4000, 16'hC000, 16'h7FFF, 16'h8000};
    foreach (vals[i]) begin
      if (i == 1)
        set_angles(16'h4000, 16'hC000, 16'hC000, 16'h4000, 16'h4000, 16'hC000);
      else
        set_angles(vals[i], vals[i], vals[i], vals[i], vals[i], vals[i]);
      send_point(17'sd65535, 17'sd65535, 17'sd65535, 1'b1);
      send_point(-17'sd65536, -17'sd65536, -17'sd65536, 1'b0);
      send_point(17'sd65535, -17'sd65536, -17'sd32768, 1'b1);
    end
  endtask

  // Writes to indexes past the register file must change nothing
  task automatic test_unused_index();
    random_angles();
    write_angle(IDX_SPARE_LO, 16'h8000);
    write_angle(IDX_SPARE_HI, 16'h7FFF);
    send_point(17'sd20000, -17'sd15000, -17'sd3000, 1'b0);
    send_point(-17'sd32768, 17'sd32767, -17'sd32768, 1'b1);
    send_point(17'sd1, 17'sd0, -17'sd1, 1'b0);
  endtask

  task automatic test_random_sky();
    for (int phase = 0; phase < 12; phase++) begin
      random_angles();
      gap_percent = (phase % 4 == 0) ? 0 : $urandom_range(10, 90);
      repeat (88) send_random_point();
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_result
    enu_t want;
    if (rst_n && out_valid && out_ready) begin
      if (enu_expected.size() == 0) begin
        $error("unexpected result word: east %0d north %0d up %0d",
               out_east, out_north, out_up);
        err_count++;
      end else begin
        want = enu_expected.pop_front();
        if (out_east !== want.east) begin
          $error("east: expected %0d, got %0d", want.east, out_east);
          err_count++;
        end
        if (out_north !== want.north) begin
          $error("north: expected %0d, got %0d", want.north, out_north);
          err_count++;
        end
        if (out_up !== want.up) begin
          $error("up: expected %0d, got %0d", want.up, out_up);
          err_count++;
        end
        if (out_last_out !== want.last) begin
          $error("last_out: expected %0d, got %0d", want.last, out_last_out);
          err_count++;
        end
      end
    end
  end

  // Receiver back-pressure in spans of differing character
  initial begin : sink_pattern
    sink_mode_t mode;
    int span;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        unique case (mode)
          SINK_OPEN:       out_ready <= 1'b1;
          SINK_COIN:       out_ready <= ($urandom_range(0, 1) == 1);
          SINK_RARE_STALL: out_ready <= ($urandom_range(0, 15) != 0);
          default:         out_ready <= ((i % 12) < 4);
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    angle_reg[dcenu_pkg::REG_SIN_HA]  = '0;
    angle_reg[dcenu_pkg::REG_COS_HA]  = dcenu_pkg::COEF_ONE;
    angle_reg[dcenu_pkg::REG_SIN_DEC] = '0;
    angle_reg[dcenu_pkg::REG_COS_DEC] = dcenu_pkg::COEF_ONE;
    angle_reg[dcenu_pkg::REG_SIN_LAT] = '0;
    angle_reg[dcenu_pkg::REG_COS_LAT] = dcenu_pkg::COEF_ONE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_matrix();
    test_extreme_angles();
    test_unused_index();
    test_random_sky();

    drain();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dcenu_pkg.sv
rtl/dcenu_coef.sv
rtl/dcenu_front.sv
rtl/dcenu_fifo.sv
rtl/dcenu_back.sv
rtl/direction_cosine_to_enu_rotation_top.sv
tb/sv/direction_cosine_to_enu_rotation_top_tb.sv
